FILE: rtl/fdiv_pkg.sv
// Shared types, status codes and helpers for the single-precision divider.
// Depends on nothing; every rtl file imports it.
package fdiv_pkg;

  localparam int SigW          = 24;  // significand with hidden bit
  localparam int ExpW          = 8;
  localparam int EW            = 11;  // signed working exponent
  localparam int QW            = 25;  // quotient bits kept
  localparam int StepsPerStage = 4;
  localparam int DivStages     = 6;

  localparam logic [2:0] ST_NORMAL   = 3'd0;
  localparam logic [2:0] ST_ZERO_DIV = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_UNDERFL  = 3'd4;

  localparam logic [ExpW-1:0] ExpMax  = 8'hFF;
  localparam logic [30:0]     InfBits = 31'h7F800000;
  localparam logic signed [EW-1:0] ExpBias  = 11'sd127;
  localparam logic signed [EW-1:0] ExpLimit = 11'sd255;

  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic [2:0]             status;
    logic signed [EW-1:0]   exp;
  } ctrl_t;

  typedef struct packed {
    logic [SigW-1:0] rem;
    logic [SigW-1:0] dsr;
    logic [QW-1:0]   quo;
    ctrl_t           ctrl;
  } div_t;

  // Count zeros above the leading one of a 24-bit significand.
  function automatic logic [4:0] lead_zeros(input logic [SigW-1:0] v);
    logic [4:0] cnt;
    cnt = 5'd0;
    for (int i = 0; i < SigW; i++) begin
      if (v[i]) begin
        cnt = 5'(SigW - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/float32_divider_core.sv
// Pipelined single-precision divider on raw bit patterns, truncating.
// Depends on fdiv_pkg and fdiv_div_stage.
//
// Usage:
//   Input channel (in_*): one transaction carries a dividend and a divisor
//   bit pattern in in_tdata. Output channel (out_*): one transaction carries
//   the quotient bits in out_tdata and a status code in out_tuser
//   (normal, zero dividend, divide by zero, overflow, underflow).
//   Every input transaction yields exactly one output transaction, in order.
// Timing:
//   Nine register stages: unpack and leading-zero count, normalize plus the
//   top quotient bit, six divider slices of four quotient bits each, pack.
//   One transaction enters per cycle while the output is not stalled; the
//   one-bit-per-step restoring divider is cut into six slices.
// Stall:
//   Each stage advances when it is empty or the stage after it advances, so
//   a stalled receiver holds out_* stable and the pipe fills behind it;
//   bubbles collapse, nothing is dropped or repeated.
// Reset:
//   rst_n low clears all valid bits; the data registers are not reset.
// NaN and infinity operands are treated as ordinary exponent codes.
module float32_divider_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] dividend_bits, [63:32] divisor_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] quotient_bits
  output logic [2:0]  out_tuser   // [2:0] status
);
  import fdiv_pkg::*;

  // ---------------- stage 1: unpack, classify, count leading zeros
  logic            s1_v_r;
  ctrl_t           s1_ctrl_r, s1_ctrl_nxt;
  logic [SigW-1:0] s1_sx_r, s1_sy_r, s1_sx_nxt, s1_sy_nxt;
  logic [4:0]      s1_shx_r, s1_shy_r;
  logic            en_s1, en_s2, en_out;

  always_comb begin
    logic [31:0]          x;
    logic [31:0]          y;
    logic [ExpW-1:0]      ex;
    logic [ExpW-1:0]      ey;
    logic signed [EW-1:0] e0;
    x  = in_tdata[31:0];
    y  = in_tdata[63:32];
    ex = x[30:23];
    ey = y[30:23];
    s1_sx_nxt = {(ex != '0), x[22:0]};
    s1_sy_nxt = {(ey != '0), y[22:0]};
    e0 = $signed({3'b0, ex}) - $signed({3'b0, ey}) + ExpBias;
    s1_ctrl_nxt.sign    = x[31] ^ y[31];
    s1_ctrl_nxt.exp     = e0;
    s1_ctrl_nxt.special = 1'b1;
    // Zero dividend wins over zero divisor; range checks come last.
    if (x[30:0] == '0) begin
      s1_ctrl_nxt.status = ST_ZERO_DIV;
    end else if (y[30:0] == '0) begin
      s1_ctrl_nxt.status = ST_DIV_ZERO;
    end else if (e0 >= ExpLimit) begin
      s1_ctrl_nxt.status = ST_OVERFLOW;
    end else if (e0 <= 0) begin
      s1_ctrl_nxt.status = ST_UNDERFL;
    end else begin
      s1_ctrl_nxt.status  = ST_NORMAL;
      s1_ctrl_nxt.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_ctrl_r <= s1_ctrl_nxt;
      s1_sx_r   <= s1_sx_nxt;
      s1_sy_r   <= s1_sy_nxt;
      s1_shx_r  <= lead_zeros(s1_sx_nxt);
      s1_shy_r  <= lead_zeros(s1_sy_nxt);
    end
  end

  // ---------------- stage 2: normalize, adjust exponent, top quotient bit
  logic s2_v_r;
  div_t s2_r, s2_nxt;

  always_comb begin
    logic [SigW-1:0] sxn;
    logic [SigW-1:0] syn;
    sxn = s1_sx_r << s1_shx_r;
    syn = s1_sy_r << s1_shy_r;
    s2_nxt.ctrl     = s1_ctrl_r;
    s2_nxt.ctrl.exp = s1_ctrl_r.exp + $signed({6'b0, s1_shy_r})
                      - $signed({6'b0, s1_shx_r});
    s2_nxt.dsr      = syn;
    if (sxn >= syn) begin
      s2_nxt.rem = sxn - syn;
      s2_nxt.quo = {{(QW-1){1'b0}}, 1'b1};
    end else begin
      s2_nxt.rem = sxn;
      s2_nxt.quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------- stages 3..8: divider slices
  logic [DivStages:0] stg_v;
  div_t               stg_d [DivStages+1];
  logic [DivStages-1:0] adv;

  assign stg_v[0] = s2_v_r;
  assign stg_d[0] = s2_r;

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    if (k == DivStages - 1) begin : g_last
      assign adv[k] = !stg_v[k+1] || en_out;
    end else begin : g_mid
      assign adv[k] = !stg_v[k+1] || adv[k+1];
    end
    fdiv_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv[k]),
      .valid_i (stg_v[k]),
      .data_i  (stg_d[k]),
      .valid_o (stg_v[k+1]),
      .data_o  (stg_d[k+1])
    );
  end

  // ---------------- stage 9: normalize quotient, final range check, pack
  logic        out_v_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  always_comb begin
    div_t                 d;
    logic signed [EW-1:0] e;
    logic [22:0]          frac;
    logic [2:0]           st;
    d = stg_d[DivStages];
    e = d.ctrl.exp;
    if (d.quo[QW-1]) begin
      frac = d.quo[23:1];
    end else begin
      frac = d.quo[22:0];
      e    = e - 11'sd1;
    end
    if (d.ctrl.special) begin
      st = d.ctrl.status;
    end else if (e <= 0) begin
      st = ST_UNDERFL;
    end else if (e >= ExpLimit) begin
      st = ST_OVERFLOW;
    end else begin
      st = ST_NORMAL;
    end
    case (st)
      ST_NORMAL:   out_data_nxt = {d.ctrl.sign, e[ExpW-1:0], frac};
      ST_DIV_ZERO,
      ST_OVERFLOW: out_data_nxt = {d.ctrl.sign, InfBits};
      default:     out_data_nxt = {d.ctrl.sign, 31'b0};
    endcase
    out_user_nxt = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= stg_v[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  // Advance a stage when it is empty or its successor advances.
  assign en_out = !out_v_r || out_tready;
  assign en_s2  = !s2_v_r || adv[0];
  assign en_s1  = !s1_v_r || en_s2;

  assign in_tready  = en_s1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/fdiv_div_stage.sv
// One registered slice of the restoring divider: StepsPerStage (four) quotient bits per stage.
// Depends on fdiv_pkg.
module fdiv_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_i,
  input  fdiv_pkg::div_t data_i,
  output logic          valid_o,
  output fdiv_pkg::div_t data_o
);
  import fdiv_pkg::*;

  logic valid_r;
  div_t data_r;
  div_t data_nxt;

  // Shift remainder, trial subtract, keep the difference when it fits.
  always_comb begin
    logic [SigW:0]   t;
    logic [SigW-1:0] r;
    logic [QW-1:0]   q;
    r = data_i.rem;
    q = data_i.quo;
    for (int i = 0; i < StepsPerStage; i++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, data_i.dsr}) begin
        t = t - {1'b0, data_i.dsr};
        q = {q[QW-2:0], 1'b1};
      end else begin
        q = {q[QW-2:0], 1'b0};
      end
      r = t[SigW-1:0];
    end
    data_nxt      = data_i;
    data_nxt.rem  = r;
    data_nxt.quo  = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

FILE: rtl/fdiv_checker.sv
// Port-level checks for the divider core, attached by bind.
// Depends on fdiv_pkg and float32_divider_core.
module fdiv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import fdiv_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output changed");

  a_inf_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DIV_ZERO || out_tuser == ST_OVERFLOW)
      |-> out_tdata[30:0] == InfBits)
    else $error("infinity status without infinity pattern");

  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO_DIV || out_tuser == ST_UNDERFL)
      |-> out_tdata[30:0] == 31'b0)
    else $error("zero status without zero pattern");

  a_normal_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_NORMAL
      |-> out_tdata[30:23] != 8'h00 && out_tdata[30:23] != ExpMax)
    else $error("normal result with reserved exponent");

endmodule

bind float32_divider_core fdiv_checker u_fdiv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
